FILE: rtl/bhd_pkg.sv
package bhd_pkg;

  localparam int ROW_COUNT     = 64;
  localparam int NODE_W        = 6;
  localparam int DIST_W        = 6;
  localparam int DEF_MAX_NODES = 64;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

endpackage

FILE: rtl/bhd_ram.sv
module bhd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/bhd_pick.sv
module bhd_pick #(
  parameter int WIDTH = 64,
  parameter int IDX_W = 6
) (
  input  logic [WIDTH-1:0] pool,
  output logic             any,
  output logic [WIDTH-1:0] onehot,
  output logic [IDX_W-1:0] idx
);

  // Two's complement isolates the lowest set bit in one add.
  assign onehot = pool & (~pool + WIDTH'(1));
  assign any    = |pool;

  always_comb begin
    idx = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (onehot[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
  end

endmodule

FILE: rtl/bfs_hop_distance.sv
// Clear completes as it is accepted; add-edge writes row A, reads row B, then writes row B.
// A query with an out-of-range node or with source equal to target goes straight to the
// emit state, which registers its result. A search issues one adjacency row read per
// reached node and steps level by level; the single adjacency RAM read port paces it.
// Throughput: one transaction at a time; input stalls until the current one is finished.
// Reset clears the control state and the per-row valid bits, so the graph is empty at once.
module bfs_hop_distance
  import bhd_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        opcode,
  input  logic [NODE_W-1:0] node_a,
  input  logic [NODE_W-1:0] node_b,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              reachable,
  output logic [DIST_W-1:0] hop_count
);

  localparam int NODE_LIMIT = (MAX_NODES < ROW_COUNT) ? MAX_NODES : ROW_COUNT;
  localparam int IDX_W      = $clog2(NODE_LIMIT);
  localparam logic [NODE_W:0] LIMIT_VAL = (NODE_W + 1)'(NODE_LIMIT);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_ADD_WR_A = 6'b000010,
    S_ADD_RD_B = 6'b000100,
    S_ADD_WR_B = 6'b001000,
    S_SEARCH   = 6'b010000,
    S_EMIT     = 6'b100000
  } state_t;

  state_t                state;
  logic [NODE_LIMIT-1:0] row_vld;
  logic                  rd_ok;
  logic [IDX_W-1:0]      edge_a;
  logic [IDX_W-1:0]      edge_b;
  logic [IDX_W-1:0]      tgt;
  logic [NODE_LIMIT-1:0] visited;
  logic [NODE_LIMIT-1:0] frontier;
  logic [NODE_LIMIT-1:0] next_front;
  logic [DIST_W-1:0]     level;
  logic                  pend;
  logic                  res_found;
  logic [DIST_W-1:0]     res_dist;

  logic                  a_in;
  logic                  b_in;
  logic [IDX_W-1:0]      a_idx;
  logic [IDX_W-1:0]      b_idx;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [NODE_LIMIT-1:0] ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [NODE_LIMIT-1:0] ram_rdata;
  logic [NODE_LIMIT-1:0] row_eff;
  logic [NODE_LIMIT-1:0] fresh;
  logic                  pick_any;
  logic [NODE_LIMIT-1:0] pick_onehot;
  logic [IDX_W-1:0]      pick_idx;

  assign a_in  = {1'b0, node_a} < LIMIT_VAL;
  assign b_in  = {1'b0, node_b} < LIMIT_VAL;
  assign a_idx = node_a[IDX_W-1:0];
  assign b_idx = node_b[IDX_W-1:0];

  assign in_stall = (state != S_IDLE);

  // A row that was never written since the last clear reads as empty.
  assign row_eff = rd_ok ? ram_rdata : '0;
  assign fresh   = pend ? (row_eff & ~visited) : '0;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = edge_a;
    ram_wdata = row_eff | (NODE_LIMIT'(1) << edge_b);
    unique case (state)
      S_IDLE:     ram_raddr = a_idx;
      S_ADD_RD_B: ram_raddr = edge_b;
      S_SEARCH:   ram_raddr = pick_idx;
      default:    ram_raddr = edge_a;
    endcase
    if (state == S_ADD_WR_A) begin
      ram_we = 1'b1;
    end else if (state == S_ADD_WR_B) begin
      ram_we    = 1'b1;
      ram_waddr = edge_b;
      ram_wdata = row_eff | (NODE_LIMIT'(1) << edge_a);
    end
  end

  bhd_ram #(
    .WIDTH (NODE_LIMIT),
    .DEPTH (NODE_LIMIT)
  ) u_adj (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bhd_pick #(
    .WIDTH (NODE_LIMIT),
    .IDX_W (IDX_W)
  ) u_pick (
    .pool   (frontier),
    .any    (pick_any),
    .onehot (pick_onehot),
    .idx    (pick_idx)
  );

  always_ff @(posedge clk) begin
    rd_ok <= row_vld[ram_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_vld   <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (opcode)
              OP_CLEAR: row_vld <= '0;
              OP_ADD: begin
                if (a_in && b_in) begin
                  edge_a <= a_idx;
                  edge_b <= b_idx;
                  state  <= S_ADD_WR_A;
                end
              end
              OP_QUERY: begin
                if (!(a_in && b_in)) begin
                  res_found <= 1'b0;
                  res_dist  <= '0;
                  state     <= S_EMIT;
                end else if (a_idx == b_idx) begin
                  res_found <= 1'b1;
                  res_dist  <= '0;
                  state     <= S_EMIT;
                end else begin
                  visited    <= NODE_LIMIT'(1) << a_idx;
                  frontier   <= NODE_LIMIT'(1) << a_idx;
                  next_front <= '0;
                  level      <= '0;
                  pend       <= 1'b0;
                  tgt        <= b_idx;
                  state      <= S_SEARCH;
                end
              end
              default: ;
            endcase
          end
        end
        S_ADD_WR_A: begin
          row_vld[edge_a] <= 1'b1;
          state           <= S_ADD_RD_B;
        end
        S_ADD_RD_B: state <= S_ADD_WR_B;
        S_ADD_WR_B: begin
          row_vld[edge_b] <= 1'b1;
          state           <= S_IDLE;
        end
        S_SEARCH: begin
          // The row fetched last cycle is merged while the next frontier node is fetched.
          if (fresh[tgt]) begin
            res_found <= 1'b1;
            res_dist  <= level + DIST_W'(1);
            pend      <= 1'b0;
            state     <= S_EMIT;
          end else begin
            visited    <= visited | fresh;
            next_front <= next_front | fresh;
            if (pick_any) begin
              frontier <= frontier & ~pick_onehot;
              pend     <= 1'b1;
            end else begin
              pend <= 1'b0;
              if (!pend) begin
                if (next_front == '0) begin
                  res_found <= 1'b0;
                  res_dist  <= '0;
                  state     <= S_EMIT;
                end else begin
                  frontier   <= next_front;
                  next_front <= '0;
                  level      <= level + DIST_W'(1);
                end
              end
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            reachable <= res_found;
            hop_count <= res_dist;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reachable |-> hop_count == '0)
    else $error("unreachable result carries a nonzero hop count");

  a_sets_visited: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> ((frontier | next_front) & ~visited) == '0)
    else $error("frontier node not marked visited");

  a_visited_grows: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH && $past(state) == S_SEARCH |-> ($past(visited) & ~visited) == '0)
    else $error("visited mark lost during search");

endmodule
